FILE: hw/rtl/kpe_pkg.sv
package kpe_pkg;

  // Field and datapath widths
  localparam int unsigned DIST_W  = 16;
  localparam int unsigned KVAL_W  = 17;   // kernel value, Q1.16
  localparam int unsigned PROD_W  = 32;   // running product, Q2.30
  localparam int unsigned SEL_W   = 3;
  localparam int unsigned WGT_W   = 25;   // 1 - u^2 in Q1.24, up to and including 1.0
  localparam int unsigned ROM_W   = 16;

  localparam int unsigned TABLE_DEPTH_DFLT = 1024;
  localparam int unsigned QUEUE_DEPTH_DFLT = 4;

  localparam logic [PROD_W-1:0] PRODUCT_ONE = 32'h4000_0000;
  localparam logic [DIST_W-1:0] UNIT_Q12    = 16'd4096;
  localparam logic [KVAL_W-1:0] UNIFORM_VAL = 17'd32768;

  // kernel_select register codes
  localparam logic [SEL_W-1:0] SEL_GAUSS = 3'd0;
  localparam logic [SEL_W-1:0] SEL_EPAN  = 3'd1;
  localparam logic [SEL_W-1:0] SEL_UNI   = 3'd2;
  localparam logic [SEL_W-1:0] SEL_TRI   = 3'd3;
  localparam logic [SEL_W-1:0] SEL_COS   = 3'd4;

  typedef enum logic [2:0] {
    KIND_GAUSS,
    KIND_EPAN,
    KIND_UNI,
    KIND_TRI,
    KIND_COS
  } kpe_kind_t;

  typedef struct packed {
    logic signed [DIST_W-1:0] distance;
    logic                     last_dimension;
  } kpe_in_t;

  typedef struct packed {
    logic [PROD_W-1:0] weight;
    logic              saturated;
  } kpe_out_t;

  // One evaluated kernel value on its way to the product stage
  typedef struct packed {
    logic              last;
    logic [KVAL_W-1:0] kval;
  } kpe_entry_t;

  // ---------------------------------------------------------------------
  // Elaboration-time table generation, Q8.56 integer arithmetic
  // ---------------------------------------------------------------------
  localparam int unsigned Q_FRAC = 56;
  localparam logic [63:0] Q_ONE  = 64'h0100_0000_0000_0000;

  // Restoring long division, quotient only
  function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  function automatic logic [63:0] mulsh(input logic [63:0] a, input logic [63:0] b,
                                        input int unsigned sh, input logic [63:0] add);
    logic [127:0] full;
    full = {64'd0, a} * {64'd0, b} + {64'd0, add};
    full = full >> sh;
    return full[63:0];
  endfunction

  function automatic logic [63:0] fmul(input logic [63:0] a, input logic [63:0] b);
    return mulsh(a, b, Q_FRAC, 64'd0);
  endfunction

  function automatic logic [63:0] ratio(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [63:0] r;
    logic [63:0] hi;
    logic [63:0] r2;
    logic [63:0] lo;
    q  = div_u64(num, den);
    r  = num - q * den;
    hi = div_u64(r << 28, den);
    r2 = (r << 28) - hi * den;
    lo = div_u64(r2 << 28, den);
    return (q << Q_FRAC) | (hi << 28) | lo;
  endfunction

  function automatic logic [63:0] atan_inv(input logic [63:0] n);
    logic [63:0] p;
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] t;
    logic [63:0] kk;
    p   = div_u64(Q_ONE, n);
    pos = '0;
    neg = '0;
    for (int k = 0; k < 48; k++) begin
      if (p != 64'd0) begin
        kk = 64'(k);
        t  = div_u64(p, 2 * kk + 64'd1);
        if (kk[0]) neg = neg + t;
        else       pos = pos + t;
        p = div_u64(p, n * n);
      end
    end
    return pos - neg;
  endfunction

  function automatic logic [63:0] calc_pi();
    return (atan_inv(64'd5) << 4) - (atan_inv(64'd239) << 2);
  endfunction

  // 1/sqrt(2*pi) by Newton iteration
  function automatic logic [63:0] calc_gauss_norm(input logic [63:0] pi_q);
    logic [63:0] two_pi;
    logic [63:0] c;
    two_pi = pi_q << 1;
    c      = ratio(64'd2, 64'd5);
    for (int it = 0; it < 8; it++) begin
      c = fmul(c, 3 * Q_ONE - fmul(two_pi, fmul(c, c))) >> 1;
    end
    return c;
  endfunction

  function automatic logic [ROM_W-1:0] to_q16(input logic [63:0] v);
    logic [63:0] s;
    s = v + (64'd1 << (Q_FRAC - 17));
    return s[Q_FRAC-16 +: ROM_W];
  endfunction

  function automatic logic [ROM_W-1:0] gauss_entry(input int unsigned i,
                                                   input int unsigned depth,
                                                   input logic [63:0] norm);
    logic [63:0] x;
    logic [63:0] s;
    logic [63:0] term;
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] e;
    logic [63:0] kk;
    x    = ratio(64'd8 * 64'(i), 64'(depth));
    s    = fmul(x, x) >> 7;
    term = Q_ONE;
    pos  = Q_ONE;
    neg  = '0;
    for (int k = 1; k <= 30; k++) begin
      kk   = 64'(k);
      term = div_u64(fmul(term, s), kk);
      if (kk[0]) neg = neg + term;
      else       pos = pos + term;
    end
    // exp(-x^2/2) = exp(-x^2/128)^64
    e = pos - neg;
    for (int it = 0; it < 6; it++) begin
      e = fmul(e, e);
    end
    return to_q16(fmul(e, norm));
  endfunction

  function automatic logic [ROM_W-1:0] cos_entry(input int unsigned i,
                                                 input int unsigned depth,
                                                 input logic [63:0] pi_q);
    logic [63:0] th;
    logic [63:0] th2;
    logic [63:0] term;
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] kk;
    th   = fmul(pi_q, ratio(64'(i), 64'd2 * 64'(depth)));
    th2  = fmul(th, th);
    term = Q_ONE;
    pos  = Q_ONE;
    neg  = '0;
    for (int k = 1; k <= 25; k++) begin
      kk   = 64'(k);
      term = div_u64(fmul(term, th2), (2 * kk - 64'd1) * (2 * kk));
      if (kk[0]) neg = neg + term;
      else       pos = pos + term;
    end
    return to_q16(fmul(pos - neg, pi_q >> 2));
  endfunction

endpackage

FILE: hw/rtl/kpe_front.sv
module kpe_front #(
  parameter int unsigned TABLE_DEPTH = kpe_pkg::TABLE_DEPTH_DFLT
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  kpe_pkg::kpe_in_t                in_data,
  input  logic                            cfg_wr_en,
  input  logic [kpe_pkg::SEL_W-1:0]       cfg_wr_data,
  output logic                            push,
  output kpe_pkg::kpe_entry_t             push_data,
  input  logic                            q_full
);

  localparam int unsigned IDX_W  = $clog2(TABLE_DEPTH);
  localparam int unsigned DEP_W  = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned IPR_W  = kpe_pkg::DIST_W + DEP_W;
  localparam int unsigned WSQ_W  = 2 * kpe_pkg::WGT_W - 1;   // (1.0)^2 needs 49 bits
  localparam int unsigned W35_W  = kpe_pkg::WGT_W + 5;
  localparam int unsigned WSQ_LO = kpe_pkg::WGT_W - 1;
  localparam int unsigned PH_W   = (WSQ_W - WSQ_LO) + W35_W;
  localparam int unsigned PL_W   = WSQ_LO + W35_W;
  localparam int unsigned TSUM_W = PH_W + WSQ_LO;
  localparam int unsigned TRI_SH = 61;

  localparam logic [63:0] PI_Q   = kpe_pkg::calc_pi();
  localparam logic [63:0] NORM_Q = kpe_pkg::calc_gauss_norm(PI_Q);

  // Constant tables, built at elaboration
  logic [kpe_pkg::ROM_W-1:0] gauss_tab [TABLE_DEPTH];
  logic [kpe_pkg::ROM_W-1:0] cos_tab   [TABLE_DEPTH];

  for (genvar gi = 0; gi < TABLE_DEPTH; gi++) begin : g_rom
    localparam logic [kpe_pkg::ROM_W-1:0] G_VAL = kpe_pkg::gauss_entry(gi, TABLE_DEPTH, NORM_Q);
    localparam logic [kpe_pkg::ROM_W-1:0] C_VAL = kpe_pkg::cos_entry(gi, TABLE_DEPTH, PI_Q);
    assign gauss_tab[gi] = G_VAL;
    assign cos_tab[gi]   = C_VAL;
  end

  logic [kpe_pkg::SEL_W-1:0] ksel_r;

  logic adv;

  // stage 1: magnitude and kernel kind
  logic                        v1_r;
  logic [kpe_pkg::DIST_W-1:0]  a1_r;
  kpe_pkg::kpe_kind_t          kind1_r;
  logic                        last1_r;
  logic [kpe_pkg::DIST_W-1:0]  dist_u;
  logic [kpe_pkg::DIST_W-1:0]  a_in;
  kpe_pkg::kpe_kind_t          kind_in;

  // stage 2: support, 1 - u^2, table index
  logic                        v2_r;
  kpe_pkg::kpe_kind_t          kind2_r;
  logic                        last2_r;
  logic                        zero2_r;
  logic [kpe_pkg::WGT_W-1:0]   w2_r;
  logic [IDX_W-1:0]            idx2_r;
  logic                        zero_c;
  logic [2*13-1:0]             sq_c;
  logic [IPR_W-1:0]            iprod_c;
  logic [IDX_W-1:0]            idx_c;

  // stage 3: direct kernel value, triweight powers
  logic                        v3_r;
  logic                        last3_r;
  logic                        tri3_r;
  logic [kpe_pkg::KVAL_W-1:0]  dval3_r;
  logic [WSQ_W-1:0]            wsq3_r;
  logic [W35_W-1:0]            w35_3_r;
  logic [kpe_pkg::WGT_W+1-1:0] ep_sum_c;
  logic [kpe_pkg::ROM_W-1:0]   tab_c;
  logic [kpe_pkg::KVAL_W-1:0]  dval_c;
  logic [2*kpe_pkg::WGT_W-1:0] wsq_full_c;
  logic [W35_W-1:0]            w35_c;

  // stage 4: triweight partial products
  logic                        v4_r;
  logic                        last4_r;
  logic                        tri4_r;
  logic [kpe_pkg::KVAL_W-1:0]  dval4_r;
  logic [PH_W-1:0]             ph4_r;
  logic [PL_W-1:0]             pl4_r;
  logic [TSUM_W-1:0]           tsum_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ksel_r <= kpe_pkg::SEL_GAUSS;
    end else if (cfg_wr_en) begin
      ksel_r <= cfg_wr_data;
    end
  end

  // stall every stage together while the queue cannot take the oldest item
  assign adv      = !v4_r || !q_full;
  assign in_ready = adv;

  always_comb begin
    dist_u = in_data.distance;
    a_in   = dist_u[kpe_pkg::DIST_W-1] ? (~dist_u + 16'd1) : dist_u;
    unique case (ksel_r)
      kpe_pkg::SEL_GAUSS: kind_in = kpe_pkg::KIND_GAUSS;
      kpe_pkg::SEL_EPAN:  kind_in = kpe_pkg::KIND_EPAN;
      kpe_pkg::SEL_UNI:   kind_in = kpe_pkg::KIND_UNI;
      kpe_pkg::SEL_TRI:   kind_in = kpe_pkg::KIND_TRI;
      kpe_pkg::SEL_COS:   kind_in = kpe_pkg::KIND_COS;
      default:            kind_in = kpe_pkg::KIND_GAUSS;
    endcase
  end

  always_comb begin
    unique case (kind1_r)
      kpe_pkg::KIND_GAUSS: zero_c = a1_r[kpe_pkg::DIST_W-1];
      kpe_pkg::KIND_COS:   zero_c = (a1_r >= kpe_pkg::UNIT_Q12);
      default:             zero_c = (a1_r > kpe_pkg::UNIT_Q12);
    endcase
    sq_c    = a1_r[12:0] * a1_r[12:0];
    iprod_c = IPR_W'(a1_r) * IPR_W'(TABLE_DEPTH);
    if (zero_c) begin
      idx_c = '0;
    end else if (kind1_r == kpe_pkg::KIND_COS) begin
      idx_c = iprod_c[12 +: IDX_W];
    end else begin
      idx_c = iprod_c[15 +: IDX_W];
    end
  end

  always_comb begin
    ep_sum_c   = 26'({w2_r, 1'b0}) + 26'(w2_r) + 26'd512;
    tab_c      = (kind2_r == kpe_pkg::KIND_COS) ? cos_tab[idx2_r] : gauss_tab[idx2_r];
    wsq_full_c = 50'(w2_r) * 50'(w2_r);
    w35_c      = W35_W'({w2_r, 5'b0}) + W35_W'({w2_r, 1'b0}) + W35_W'(w2_r);
    if (zero2_r) begin
      dval_c = '0;
    end else begin
      unique case (kind2_r)
        kpe_pkg::KIND_GAUSS,
        kpe_pkg::KIND_COS:  dval_c = kpe_pkg::KVAL_W'(tab_c);
        kpe_pkg::KIND_EPAN: dval_c = kpe_pkg::KVAL_W'(ep_sum_c[25:10]);
        kpe_pkg::KIND_UNI:  dval_c = kpe_pkg::UNIFORM_VAL;
        default:            dval_c = '0;
      endcase
    end
  end

  // 35 * w^3, rounded, over 2^61
  assign tsum_c = {ph4_r, WSQ_LO'(0)} + TSUM_W'(pl4_r) + (TSUM_W'(1) << (TRI_SH - 1));

  assign push           = v4_r && !q_full;
  assign push_data.last = last4_r;
  assign push_data.kval = tri4_r ? tsum_c[TRI_SH +: kpe_pkg::KVAL_W] : dval4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a1_r    <= a_in;
      kind1_r <= kind_in;
      last1_r <= in_data.last_dimension;

      kind2_r <= kind1_r;
      last2_r <= last1_r;
      zero2_r <= zero_c;
      w2_r    <= kpe_pkg::WGT_W'(26'h100_0000 - sq_c);
      idx2_r  <= idx_c;

      last3_r <= last2_r;
      tri3_r  <= (kind2_r == kpe_pkg::KIND_TRI) && !zero2_r;
      dval3_r <= dval_c;
      wsq3_r  <= wsq_full_c[WSQ_W-1:0];
      w35_3_r <= w35_c;

      last4_r <= last3_r;
      tri4_r  <= tri3_r;
      dval4_r <= dval3_r;
      ph4_r   <= PH_W'(wsq3_r[WSQ_W-1:WSQ_LO]) * PH_W'(w35_3_r);
      pl4_r   <= PL_W'(wsq3_r[WSQ_LO-1:0]) * PL_W'(w35_3_r);
    end
  end

endmodule

FILE: hw/rtl/kpe_queue.sv
module kpe_queue #(
  parameter int unsigned DEPTH = kpe_pkg::QUEUE_DEPTH_DFLT
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  kpe_pkg::kpe_entry_t  wr_data,
  output logic                 full,
  input  logic                 rd_en,
  output kpe_pkg::kpe_entry_t  rd_data,
  output logic                 empty
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  kpe_pkg::kpe_entry_t mem_r [DEPTH];
  logic [PTR_W-1:0]    wr_ptr_r;
  logic [PTR_W-1:0]    rd_ptr_r;
  logic [CNT_W-1:0]    count_r;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign rd_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (rd_en) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count_r <= count_r + 1'b1;
      end else if (rd_en && !wr_en) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

FILE: hw/rtl/kpe_back.sv
module kpe_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_empty,
  input  kpe_pkg::kpe_entry_t  q_head,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output kpe_pkg::kpe_out_t    out_data
);

  localparam int unsigned MUL_W = kpe_pkg::PROD_W + kpe_pkg::KVAL_W;

  logic [kpe_pkg::PROD_W-1:0] prod_r;
  logic                       clip_r;
  logic                       out_valid_r;
  kpe_pkg::kpe_out_t          out_data_r;

  logic [MUL_W-1:0]           mul_c;
  logic                       ovf_c;
  logic [kpe_pkg::PROD_W-1:0] prod_nxt;

  // take the next kernel value only when a finished weight has somewhere to go
  assign q_pop = !q_empty && (!out_valid_r || out_ready);

  always_comb begin
    mul_c    = MUL_W'(prod_r) * MUL_W'(q_head.kval);
    ovf_c    = mul_c[MUL_W-1];
    prod_nxt = ovf_c ? '1 : mul_c[16 +: kpe_pkg::PROD_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_r      <= kpe_pkg::PRODUCT_ONE;
      clip_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        if (q_head.last) begin
          prod_r <= kpe_pkg::PRODUCT_ONE;
          clip_r <= 1'b0;
        end else begin
          prod_r <= prod_nxt;
          clip_r <= clip_r | ovf_c;
        end
      end
      if (q_pop && q_head.last) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_head.last) begin
      out_data_r.weight    <= prod_nxt;
      out_data_r.saturated <= clip_r | ovf_c;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: hw/rtl/kernel_product_evaluator_unit.sv
// Product-kernel weight unit.
// Input channel (in_valid/in_ready/in_data): one scaled distance per
// transaction, Q4.12, one transaction per dimension; last_dimension closes
// the point. Output channel (out_valid/out_ready/out_data): one weight per
// point, the product of the kernel values in Q2.30 with a flag set if the
// product clipped at its maximum anywhere within that point.
// Configuration: cfg_wr_en/cfg_wr_data write the kernel selector; change it
// only between points with the unit drained.
// Throughput: one distance per cycle while the receiver does not stall, set
// by the single 32x17 multiply and clip in the product stage. After the
// accepting edge of the last distance it passes three further kernel stages,
// the queue and the product stage to out_valid, behind any earlier items.
// Reset clears the pipeline, the queue, the running product (to 1.0), the
// clip flag and the selector (gaussian). When the receiver stalls, the
// product stage holds behind the output register, the queue fills, and
// in_ready drops once the queue is full and the last kernel stage holds a
// transaction.
module kernel_product_evaluator_unit #(
  parameter int unsigned TABLE_DEPTH = kpe_pkg::TABLE_DEPTH_DFLT,
  parameter int unsigned QUEUE_DEPTH = kpe_pkg::QUEUE_DEPTH_DFLT
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  kpe_pkg::kpe_in_t           in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output kpe_pkg::kpe_out_t          out_data,
  input  logic                       cfg_wr_en,
  input  logic [kpe_pkg::SEL_W-1:0]  cfg_wr_data
);

  logic                q_push;
  kpe_pkg::kpe_entry_t q_wr_data;
  logic                q_full;
  logic                q_pop;
  kpe_pkg::kpe_entry_t q_head;
  logic                q_empty;

  kpe_front #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .push        (q_push),
    .push_data   (q_wr_data),
    .q_full      (q_full)
  );

  kpe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_push),
    .wr_data (q_wr_data),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_data (q_head),
    .empty   (q_empty)
  );

  kpe_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
